@@ hdl/tbda_pkg.sv @@
// Shared types, mode codes and slice sizes for the ternary/binary dot accumulator.
// No dependencies; every other file in hdl imports this package.
package tbda_pkg;

    // Bits handled by one lane unit
    localparam int SLICE_W  = 8;
    // Per-lane popcount width (0..SLICE_W)
    localparam int LCNT_W   = 4;
    // Per-tap count width (0..127)
    localparam int TCNT_W   = 7;
    // Running total and result widths
    localparam int TOTAL_W  = 16;
    localparam int DOT_W    = 17;
    // Input field widths
    localparam int WORD_W   = 32;
    localparam int CH_W     = 6;

    // Defaults for the top-level parameters
    localparam int LANES_DEF    = 32;
    localparam int MAX_TAPS_DEF = 1024;

    // Mode register codes
    localparam logic [1:0] MODE_BXOR = 2'd0;
    localparam logic [1:0] MODE_TBN  = 2'd1;
    localparam logic [1:0] MODE_TNN  = 2'd2;

    // Register byte addresses (bit 2 of paddr selects the word)
    localparam logic [2:0] ADDR_MODE = 3'd0;

    // Counts found by one lane unit
    typedef struct packed {
        logic [LCNT_W-1:0] plus;
        logic [LCNT_W-1:0] minus;
    } t_lane_cnt;

    // Per-tap control that travels beside the lane counts
    typedef struct packed {
        logic            inb;
        logic            last;
        logic            bxor;
        logic [CH_W-1:0] ch;
    } t_tap_ctl;

    // Population count of one slice
    function automatic logic [LCNT_W-1:0] pop_slice(input logic [SLICE_W-1:0] v);
        logic [LCNT_W-1:0] c;
        c = '0;
        for (int i = 0; i < SLICE_W; i++) begin
            c = c + LCNT_W'(v[i]);
        end
        return c;
    endfunction

endpackage

@@ hdl/ternary_binary_dot_accumulator_unit.sv @@
// Ternary/binary dot accumulator: top level with stream ports, mode register and lanes.
// Depends on tbda_pkg, tbda_lane and tbda_merge.
//
// One kernel tap enters per beat on the s_axis channel; the final tap of a window is
// flagged on s_axis_tlast and in_bounds travels on s_axis_tuser. Padding taps add
// nothing. Each window gives one result beat on m_axis: dot_sum, plus_count and
// minus_count. Taps without tlast give no result beat.
// Throughput: one tap per cycle while no unread result holds the stream, set by the
// lane popcount stage feeding the accumulate-and-saturate logic in the merge stage.
// Path: the edge that takes the last tap loads the lane count register, and the edge
// on which the merge stage takes that beat loads the result register, which makes the
// result beat valid; an unread result can hold the merge stage in between.
// Stalls: the lane stage keeps accepting while a result waits, until it is full; an
// unread result then holds s_axis_tready low. No result is lost or repeated.
// Reset (synchronous, active low) clears the totals, the valid flags and mode to
// binary. The mode register lies at byte address 0 of the APB port and must only be
// written while no tap is in flight. Totals saturate at min(MAX_TAPS*LANES, 65535).
module ternary_binary_dot_accumulator_unit
    import tbda_pkg::*;
#(
    parameter int LANES    = LANES_DEF,
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // tap beats
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // act_plus[31:0], act_minus[63:32], weight_plus[95:64], weight_minus[127:96],
    // active_channels[133:128], zero pad [135:134]
    input  logic [135:0] s_axis_tdata,
    // in_bounds[0]
    input  logic [0:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    // result beats
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // dot_sum[16:0], plus_count[32:17], minus_count[48:33], zero pad [55:49]
    output logic [55:0]  m_axis_tdata,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int W    = (LANES > WORD_W) ? WORD_W : LANES;
    localparam int NGRP = (W + SLICE_W - 1) / SLICE_W;
    localparam int PW   = NGRP * SLICE_W;

    logic [1:0]            r_mode;
    logic                  r_v1, n_v1;
    t_tap_ctl              r_ctl;
    t_tap_ctl              n_ctl;
    logic                  w_adv;
    logic                  w_en1;
    logic [CH_W-1:0]       w_ch;
    logic [CH_W-1:0]       w_chcl;
    logic [PW-1:0]         w_valid;
    logic [PW-1:0]         w_chmask;
    logic [PW-1:0]         w_ap, w_am, w_wp, w_wm;
    t_lane_cnt [NGRP-1:0]  w_cnt;
    logic [DOT_W-1:0]      w_dot;
    logic [TOTAL_W-1:0]    w_plus;
    logic [TOTAL_W-1:0]    w_minus;

    // Register port: write mode on the access cycle, read it back
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BXOR;
        end else if (psel && penable && pwrite && (paddr[2] == ADDR_MODE[2])) begin
            r_mode <= pwdata[1:0];
        end
    end
    assign prdata = (paddr[2] == ADDR_MODE[2]) ? {30'b0, r_mode} : 32'b0;

    // Clamp the channel count and build lane masks
    assign w_ch   = s_axis_tdata[4*WORD_W +: CH_W];
    assign w_chcl = ({1'b0, w_ch} > (CH_W+1)'(LANES)) ? CH_W'(LANES) : w_ch;
    always_comb begin
        for (int i = 0; i < PW; i++) begin
            w_valid[i]  = (i < W);
            w_chmask[i] = w_valid[i] && ((CH_W+1)'(i) < {1'b0, w_chcl});
        end
    end
    assign w_ap = s_axis_tdata[0*WORD_W +: PW] & w_valid;
    assign w_am = s_axis_tdata[1*WORD_W +: PW] & w_valid;
    assign w_wp = s_axis_tdata[2*WORD_W +: PW] & w_valid;
    assign w_wm = s_axis_tdata[3*WORD_W +: PW] & w_valid;

    // Lane stage accepts when empty or when the merge stage takes its beat
    assign w_en1         = !r_v1 || w_adv;
    assign s_axis_tready = w_en1;

    always_comb begin
        n_v1 = r_v1;
        if (w_en1) begin
            n_v1 = s_axis_tvalid;
        end
        n_ctl.inb  = s_axis_tuser[0];
        n_ctl.last = s_axis_tlast;
        n_ctl.bxor = (r_mode == MODE_BXOR);
        n_ctl.ch   = w_chcl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_ctl <= n_ctl;
        end
    end

    // Lane units, one per slice of the tap word
    for (genvar g = 0; g < NGRP; g++) begin : g_lane
        tbda_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (w_en1),
            .i_mode   (r_mode),
            .i_ap     (w_ap[g*SLICE_W +: SLICE_W]),
            .i_am     (w_am[g*SLICE_W +: SLICE_W]),
            .i_wp     (w_wp[g*SLICE_W +: SLICE_W]),
            .i_wm     (w_wm[g*SLICE_W +: SLICE_W]),
            .i_valid  (w_valid[g*SLICE_W +: SLICE_W]),
            .i_chmask (w_chmask[g*SLICE_W +: SLICE_W]),
            .o_cnt    (w_cnt[g])
        );
    end

    // Combine lane counts into window totals and the result beat
    tbda_merge #(
        .LANES    (LANES),
        .MAX_TAPS (MAX_TAPS),
        .NGRP     (NGRP)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_v1),
        .i_ctl     (r_ctl),
        .i_cnt     (w_cnt),
        .i_ready   (m_axis_tready),
        .o_advance (w_adv),
        .o_valid   (m_axis_tvalid),
        .o_dot     (w_dot),
        .o_plus    (w_plus),
        .o_minus   (w_minus)
    );

    assign m_axis_tdata = {7'b0, w_minus, w_plus, w_dot};

endmodule

@@ hdl/tbda_lane.sv @@
// One lane unit: products and popcounts for one slice of the tap word, registered.
// Depends on tbda_pkg.
module tbda_lane
    import tbda_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [1:0]         i_mode,
    input  logic [SLICE_W-1:0] i_ap,
    input  logic [SLICE_W-1:0] i_am,
    input  logic [SLICE_W-1:0] i_wp,
    input  logic [SLICE_W-1:0] i_wm,
    input  logic [SLICE_W-1:0] i_valid,
    input  logic [SLICE_W-1:0] i_chmask,
    output t_lane_cnt          o_cnt
);

    logic [SLICE_W-1:0] w_nw;
    logic [SLICE_W-1:0] w_pbits;
    logic [SLICE_W-1:0] w_mbits;
    t_lane_cnt          r_cnt;
    t_lane_cnt          n_cnt;

    // Form the +1 and -1 product bits for the current mode
    always_comb begin
        w_nw = ~i_wp & i_valid;
        case (i_mode)
            MODE_BXOR: begin
                w_pbits = '0;
                w_mbits = (i_ap ^ i_wp) & i_chmask;
            end
            MODE_TBN: begin
                w_pbits = (i_ap & i_wp) | (i_am & w_nw);
                w_mbits = (i_ap & w_nw) | (i_am & i_wp);
            end
            default: begin
                // mode three behaves as ternary-ternary
                w_pbits = (i_ap & i_wp) | (i_am & i_wm);
                w_mbits = (i_ap & i_wm) | (i_am & i_wp);
            end
        endcase
        n_cnt.plus  = pop_slice(w_pbits);
        n_cnt.minus = pop_slice(w_mbits);
    end

    // Hold the counts until the next stage takes them
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_cnt = r_cnt;

endmodule

@@ hdl/tbda_merge.sv @@
// Merge stage: sums lane counts, accumulates saturating totals, holds the result beat.
// Depends on tbda_pkg.
module tbda_merge
    import tbda_pkg::*;
#(
    parameter int LANES    = LANES_DEF,
    parameter int MAX_TAPS = MAX_TAPS_DEF,
    parameter int NGRP     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  t_tap_ctl             i_ctl,
    input  t_lane_cnt [NGRP-1:0] i_cnt,
    input  logic                 i_ready,
    output logic                 o_advance,
    output logic                 o_valid,
    output logic [DOT_W-1:0]     o_dot,
    output logic [TOTAL_W-1:0]   o_plus,
    output logic [TOTAL_W-1:0]   o_minus
);

    localparam int          CAP_RAW = MAX_TAPS * LANES;
    localparam int          CAP_INT = (CAP_RAW > 65535) ? 65535 : CAP_RAW;
    localparam logic [TOTAL_W:0] CAP = (TOTAL_W+1)'(CAP_INT);

    logic [TCNT_W-1:0]  w_psum;
    logic [TCNT_W-1:0]  w_msum;
    logic [TCNT_W-1:0]  w_ptap;
    logic [TCNT_W-1:0]  w_mtap;
    logic [TOTAL_W:0]   w_padd;
    logic [TOTAL_W:0]   w_madd;
    logic [TOTAL_W-1:0] w_pnew;
    logic [TOTAL_W-1:0] w_mnew;
    logic               w_take;

    logic [TOTAL_W-1:0] r_ptot, n_ptot;
    logic [TOTAL_W-1:0] r_mtot, n_mtot;
    logic               r_ov, n_ov;
    logic [DOT_W-1:0]   r_dot;
    logic [TOTAL_W-1:0] r_plus;
    logic [TOTAL_W-1:0] r_minus;

    assign o_advance = !r_ov || i_ready;
    assign w_take    = i_valid && o_advance;

    // Sum the lane counts; binary mode derives +1 from the channel count
    always_comb begin
        w_psum = '0;
        w_msum = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_psum = w_psum + TCNT_W'(i_cnt[g].plus);
            w_msum = w_msum + TCNT_W'(i_cnt[g].minus);
        end
        if (!i_ctl.inb) begin
            w_ptap = '0;
            w_mtap = '0;
        end else if (i_ctl.bxor) begin
            w_ptap = TCNT_W'(i_ctl.ch) - w_msum;
            w_mtap = w_msum;
        end else begin
            w_ptap = w_psum;
            w_mtap = w_msum;
        end
        w_padd = {1'b0, r_ptot} + (TOTAL_W+1)'(w_ptap);
        w_madd = {1'b0, r_mtot} + (TOTAL_W+1)'(w_mtap);
        w_pnew = (w_padd > CAP) ? CAP[TOTAL_W-1:0] : w_padd[TOTAL_W-1:0];
        w_mnew = (w_madd > CAP) ? CAP[TOTAL_W-1:0] : w_madd[TOTAL_W-1:0];
    end

    // Advance totals; clear them after a last tap
    always_comb begin
        n_ptot = r_ptot;
        n_mtot = r_mtot;
        n_ov   = r_ov && !i_ready;
        if (w_take) begin
            n_ov = i_ctl.last;
            if (i_ctl.last) begin
                n_ptot = '0;
                n_mtot = '0;
            end else begin
                n_ptot = w_pnew;
                n_mtot = w_mnew;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptot <= '0;
            r_mtot <= '0;
            r_ov   <= 1'b0;
        end else begin
            r_ptot <= n_ptot;
            r_mtot <= n_mtot;
            r_ov   <= n_ov;
        end
    end

    // Load the result beat at a last tap
    always_ff @(posedge i_clk) begin
        if (w_take && i_ctl.last) begin
            r_plus  <= w_pnew;
            r_minus <= w_mnew;
            r_dot   <= {1'b0, w_pnew} - {1'b0, w_mnew};
        end
    end

    assign o_valid = r_ov;
    assign o_dot   = r_dot;
    assign o_plus  = r_plus;
    assign o_minus = r_minus;

endmodule

@@ bench/testbench.sv @@
// Self-checking bench for the ternary/binary dot accumulator unit.
// Depends on tbda_pkg and ternary_binary_dot_accumulator_unit; predicts each window sum itself.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tbda_pkg::*;

    // Mode code 3 is undefined upstream and behaves as ternary-ternary
    localparam logic [1:0] MODE_SPARE  = 2'd3;
    // An address with no register behind it
    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam int TOTAL_CAP =
        (MAX_TAPS_DEF * LANES_DEF > 65535) ? 65535 : MAX_TAPS_DEF * LANES_DEF;

    typedef struct packed {
        logic [WORD_W-1:0] ap;
        logic [WORD_W-1:0] am;
        logic [WORD_W-1:0] wp;
        logic [WORD_W-1:0] wm;
        logic              inb;
        logic [CH_W-1:0]   ch;
        logic              last;
    } t_tap;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [TOTAL_W-1:0]      plus;
        logic [TOTAL_W-1:0]      minus;
    } t_window_sum;

    typedef struct packed {
        logic [1:0]              mode;
        logic [WORD_W-1:0]       ap;
        logic [WORD_W-1:0]       am;
        logic [WORD_W-1:0]       wp;
        logic [WORD_W-1:0]       wm;
        logic                    inb;
        logic [CH_W-1:0]         ch;
        logic                    last;
        logic                    typed;
        logic signed [DOT_W-1:0] dot;
        logic [TOTAL_W-1:0]      plus;
        logic [TOTAL_W-1:0]      minus;
    } t_dir_row;

    // Directed taps; rows with typed set carry a hand-worked window sum
    localparam t_dir_row DIRECTED [22] = '{
        '{MODE_BXOR, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 6'd32, 1'b1,
          1'b1, 17'sd32, 16'd32, 16'd0},
        '{MODE_BXOR, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1, 6'd32, 1'b1,
          1'b1, -17'sd32, 16'd0, 16'd32},
        '{MODE_BXOR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1,
          1'b1, -17'sd32, 16'd0, 16'd32},
        '{MODE_BXOR, 32'h5A5A_C3C3, 32'h0, 32'h0, 32'h0, 1'b1, 6'd0, 1'b1,
          1'b1, 17'sd0, 16'd0, 16'd0},
        '{MODE_BXOR, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 6'd32, 1'b0,
          1'b0, 17'sd0, 16'd0, 16'd0},
        '{MODE_BXOR, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0, 6'd32, 1'b1,
          1'b1, 17'sd0, 16'd0, 16'd0},
        '{MODE_BXOR, 32'h0000_001F, 32'h0, 32'h0, 32'h0, 1'b1, 6'd5, 1'b0,
          1'b0, 17'sd0, 16'd0, 16'd0},
        '{MODE_BXOR, 32'hFFFF_0000, 32'h0, 32'h0, 32'h0, 1'b1, 6'd32, 1'b0,
          1'b0, 17'sd0, 16'd0, 16'd0},
        '{MODE_BXOR, 32'h1234_5678, 32'h0, 32'h9ABC_DEF0, 32'h0, 1'b0, 6'd17, 1'b1,
          1'b0, 17'sd0, 16'd0, 16'd0},
        '{MODE_TBN, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 6'd32, 1'b1,
          1'b1, 17'sd32, 16'd32, 16'd0},
        '{MODE_TBN, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b1, 6'd32, 1'b1,
          1'b1, -17'sd32, 16'd0, 16'd32},
        '{MODE_TBN, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 6'd32, 1'b1,
          1'b1, 17'sd32, 16'd32, 16'd0},
        '{MODE_TBN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_AAAA, 32'h0, 1'b1, 6'd32, 1'b1,
          1'b1, 17'sd0, 16'd32, 16'd32},
        '{MODE_TBN, 32'h0F0F_0F0F, 32'h0, 32'h0F0F_0F0F, 32'hFFFF_FFFF, 1'b1, 6'd0, 1'b1,
          1'b1, 17'sd16, 16'd16, 16'd0},
        '{MODE_TNN, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 6'd0, 1'b1,
          1'b1, 17'sd32, 16'd32, 16'd0},
        '{MODE_TNN, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 6'd63, 1'b1,
          1'b1, -17'sd32, 16'd0, 16'd32},
        '{MODE_TNN, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 6'd32, 1'b1,
          1'b1, 17'sd0, 16'd0, 16'd0},
        '{MODE_TNN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 6'd32,
          1'b1, 1'b1, 17'sd0, 16'd32, 16'd32},
        '{MODE_TNN, 32'hC3A5_0F96, 32'h3C5A_F069, 32'h9669_A55A, 32'h6996_5AA5, 1'b1, 6'd32,
          1'b0, 1'b0, 17'sd0, 16'd0, 16'd0},
        '{MODE_TNN, 32'h8001_7FFE, 32'h7FFE_8001, 32'hF00F_0FF0, 32'h0FF0_F00F, 1'b1, 6'd7,
          1'b1, 1'b0, 17'sd0, 16'd0, 16'd0},
        '{MODE_SPARE, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 6'd0, 1'b1,
          1'b1, 17'sd32, 16'd32, 16'd0},
        '{MODE_SPARE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 6'd0, 1'b1,
          1'b1, 17'sd32, 16'd32, 16'd0}
    };

    localparam logic [1:0] PHASE_MODES [8] = '{
        MODE_TNN, MODE_BXOR, MODE_SPARE, MODE_TBN, MODE_BXOR, MODE_TNN, MODE_TBN, MODE_SPARE
    };

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    // act_plus, act_minus, weight_plus, weight_minus, active_channels, zero pad
    logic [135:0]  s_axis_tdata = '0;
    // in_bounds
    logic [0:0]    s_axis_tuser = '0;
    logic          s_axis_tlast = 1'b0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    // dot_sum, plus_count, minus_count, zero pad
    logic [55:0]   m_axis_tdata;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [2:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    // Predictor state
    logic [1:0]    mode_reg = MODE_BXOR;
    int            acc_plus = 0;
    int            acc_minus = 0;
    t_window_sum   pending_sums [$];

    int            mismatches = 0;
    int            taps_sent = 0;
    int            sums_checked = 0;
    int            tx_gap_rate = 0;
    int            rx_stall_rate = 0;
    int            rx_hold = 0;

    ternary_binary_dot_accumulator_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Add one tap to the running totals; return 1 and the window sum on a last tap
    function automatic bit predict_tap(input t_tap t, output t_window_sum sum);
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] nw;
        int                ch;
        int                p;
        int                m;
        p = 0;
        m = 0;
        if (t.inb) begin
            if (mode_reg == MODE_BXOR) begin
                ch = (t.ch > LANES_DEF) ? LANES_DEF : int'(t.ch);
                mask = (ch >= WORD_W) ? '1 : ((WORD_W'(1) << ch) - 1);
                m = $countones((t.ap ^ t.wp) & mask);
                p = ch - m;
            end else if (mode_reg == MODE_TBN) begin
                nw = ~t.wp;
                m = $countones((t.ap & nw) | (t.am & t.wp));
                p = $countones((t.ap & t.wp) | (t.am & nw));
            end else begin
                m = $countones((t.ap & t.wm) | (t.am & t.wp));
                p = $countones((t.ap & t.wp) | (t.am & t.wm));
            end
            acc_plus = (acc_plus + p > TOTAL_CAP) ? TOTAL_CAP : acc_plus + p;
            acc_minus = (acc_minus + m > TOTAL_CAP) ? TOTAL_CAP : acc_minus + m;
        end
        sum.dot = DOT_W'(acc_plus - acc_minus);
        sum.plus = TOTAL_W'(acc_plus);
        sum.minus = TOTAL_W'(acc_minus);
        if (!t.last) begin
            return 1'b0;
        end
        acc_plus = 0;
        acc_minus = 0;
        return 1'b1;
    endfunction

    // Word patterns biased towards the all-zero and all-one corners
    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return $urandom & $urandom;
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    function automatic t_tap random_tap(input bit last);
        t_tap t;
        t.ap = rand_word();
        t.am = rand_word();
        t.wp = rand_word();
        t.wm = rand_word();
        t.inb = ($urandom_range(0, 9) != 0);
        t.ch = ($urandom_range(0, 9) < 6) ? CH_W'(32) : CH_W'($urandom_range(0, 63));
        t.last = last;
        return t;
    endfunction

    // Drive one tap beat, hold it until taken, then book its expected sum
    task automatic send_tap(input t_tap t, input bit typed, input t_window_sum typed_sum);
        t_window_sum sum;
        int          gap;
        if (tx_gap_rate != 0 && $urandom_range(1, tx_gap_rate) == 1) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, t.ch, t.wm, t.wp, t.am, t.ap};
        s_axis_tuser  <= t.inb;
        s_axis_tlast  <= t.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        taps_sent++;
        if (predict_tap(t, sum)) begin
            pending_sums.push_back(typed ? typed_sum : sum);
        end
    endtask

    // Stop sending and wait for every window sum, then let the pipeline settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    // Write a register, then read it back in the following transfer
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_MODE) begin
            mode_reg = data[1:0];
        end
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        if (addr == ADDR_MODE && prdata !== 32'(mode_reg)) begin
            $display("%0t: mode read back mismatch: expected %0d, actual %0d",
                     $realtime, mode_reg, prdata);
            mismatches++;
        end
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver back-pressure in bursts
    always @(posedge i_clk) begin
        if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= (rx_hold == 1);
        end else if (rx_stall_rate != 0 && $urandom_range(1, rx_stall_rate) == 1) begin
            rx_hold <= $urandom_range(1, 14);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each result beat with the oldest predicted window sum
    always @(posedge i_clk) begin : result_check
        t_window_sum got;
        t_window_sum want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.dot   = m_axis_tdata[16:0];
            got.plus  = m_axis_tdata[32:17];
            got.minus = m_axis_tdata[48:33];
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result beat: dot %0d plus %0d minus %0d",
                         $realtime, got.dot, got.plus, got.minus);
                mismatches++;
            end else begin
                want = pending_sums.pop_front();
                sums_checked++;
                if (got.dot !== want.dot || got.plus !== want.plus
                        || got.minus !== want.minus) begin
                    $display({"%0t: window sum mismatch: expected dot %0d plus %0d minus %0d,",
                              " actual dot %0d plus %0d minus %0d"}, $realtime,
                             want.dot, want.plus, want.minus, got.dot, got.plus, got.minus);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        t_tap        t;
        t_window_sum hand_sum;
        logic [31:0] wdata;
        int          wlen;
        int          phase_taps;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table; the first rows rely on binary mode out of reset
        tx_gap_rate = 4;
        rx_stall_rate = 4;
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].mode != mode_reg) begin
                drain();
                write_reg(ADDR_MODE, {30'd0, DIRECTED[i].mode});
            end
            t = '{DIRECTED[i].ap, DIRECTED[i].am, DIRECTED[i].wp, DIRECTED[i].wm,
                  DIRECTED[i].inb, DIRECTED[i].ch, DIRECTED[i].last};
            hand_sum = '{DIRECTED[i].dot, DIRECTED[i].plus, DIRECTED[i].minus};
            send_tap(t, DIRECTED[i].typed, hand_sum);
        end

        // Random windows, one mode per phase; the final phase runs without idling
        for (int ph = 0; ph < 8; ph++) begin
            if (ph == 7) begin
                tx_gap_rate = 0;
                rx_stall_rate = 0;
            end else begin
                tx_gap_rate = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 3 : 9);
                rx_stall_rate = (ph % 4 == 2) ? 0 : ((ph % 2 == 0) ? 3 : 8);
            end
            drain();
            wdata = $urandom;
            wdata[1:0] = PHASE_MODES[ph];
            write_reg(ADDR_MODE, wdata);
            if (ph == 1) begin
                write_reg(ADDR_UNUSED, $urandom);
            end
            phase_taps = 0;
            while (phase_taps < 75) begin
                wlen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                   : $urandom_range(1, 8);
                for (int k = 1; k <= wlen; k++) begin
                    send_tap(random_tap(k == wlen), 1'b0, '0);
                end
                phase_taps += wlen;
            end
        end

        drain();
        $display("Covered %0d taps and %0d window sums in all four mode codes,",
                 taps_sent, sums_checked);
        $display("with padding, channel clamping and stalls on both sides.");
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
